// ===== rtl/core/rdm_pkg.sv =====
`default_nettype none

package rdm_pkg;

    localparam int unsigned CMD_W  = 8;
    localparam int unsigned POS_W  = 8;
    localparam int unsigned DIV_W  = 4;
    localparam int unsigned MAG_W  = CMD_W + 1;
    localparam int unsigned STEP_W = $clog2(MAG_W);

    localparam logic [POS_W-1:0] CENTER_POS = 8'd90;
    localparam logic [POS_W-1:0] MAX_POS    = 8'd180;

    localparam logic REG_HANDICAP = 1'b0;
    localparam logic REG_REVERSE  = 1'b1;

    localparam logic [DIV_W-1:0] HANDICAP_RESET = 4'd1;

endpackage

`default_nettype wire

// ===== rtl/core/ramped_differential_drive_mixer.sv =====
// Ramped differential drive mixer for a two-servo drive base.
// The slave stream carries one control tick per request: throttle in bits 7:0 and
// steer in bits 15:8, both signed. The kept speed and turn each move one step
// toward their commands, are mixed into left and right, divided by the handicap
// register with truncation toward zero, signed by the direction register and
// clamped, and leave on the master stream as servo positions 0..180 (left in
// bits 7:0, right in bits 15:8).
// Both divisions run on one restoring divider, one quotient bit per cycle, the
// left side first and then the right; a new request is taken only after the
// last result has moved into the output register. s_tready is high only while
// the sequencer is idle.
// When the receiver stalls, the finished result waits in the output register;
// the next request is taken and worked on, and it waits before the output
// register until that register is free.
// Reset clears the kept speed and turn, sets the handicap to one and the
// direction to forward, and empties the output register.
// The user must write configuration over the APB port while the block is idle; the block does not enforce it.
`default_nettype none

module ramped_differential_drive_mixer #(
    parameter int unsigned OUTPUT_LIMIT = 90
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,

    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [15:0] s_tdata,   // throttle_cmd[7:0], steer_cmd[15:8]

    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [15:0]      m_tdata,   // left_position[7:0], right_position[15:8]

    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);

    localparam int unsigned CMD_W  = rdm_pkg::CMD_W;
    localparam int unsigned POS_W  = rdm_pkg::POS_W;
    localparam int unsigned DIV_W  = rdm_pkg::DIV_W;
    localparam int unsigned MAG_W  = rdm_pkg::MAG_W;
    localparam int unsigned STEP_W = rdm_pkg::STEP_W;

    localparam logic [MAG_W-1:0]  LIMIT     = MAG_W'(OUTPUT_LIMIT);
    localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(MAG_W - 1);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_DIV  = 2'd1;
    localparam logic [1:0] S_DONE = 2'd2;

    logic [1:0]             state_reg, state_next;
    logic                   side_reg, side_next;
    logic [STEP_W-1:0]      step_reg, step_next;
    logic [DIV_W-1:0]       rem_reg, rem_next;
    logic [MAG_W-1:0]       quo_reg, quo_next;
    logic                   neg_reg, neg_next;
    logic [POS_W-1:0]       left_reg, left_next;
    logic [POS_W-1:0]       right_reg, right_next;
    logic signed [CMD_W-1:0] speed_reg, speed_next;
    logic signed [CMD_W-1:0] turn_reg, turn_next;
    logic [DIV_W-1:0]       handicap_reg;
    logic                   reverse_reg;
    logic                   m_tvalid_reg, m_tvalid_next;
    logic [15:0]            m_tdata_reg, m_tdata_next;

    logic signed [CMD_W-1:0] thr_cmd, str_cmd, ramp_speed, ramp_turn;
    logic signed [CMD_W-1:0] op_speed, op_turn;
    logic signed [MAG_W-1:0] mix_diff, mix_sum, mix_val;
    logic [MAG_W-1:0]        mix_mag;
    logic                    load_side;
    logic [DIV_W-1:0]        div_eff;
    logic [DIV_W:0]          trial;
    logic                    trial_ge;
    logic [MAG_W-1:0]        quo_shift;
    logic [MAG_W-1:0]        clamped;
    logic [POS_W-1:0]        position;
    logic                    s_take;
    logic                    cfg_write;

    assign thr_cmd = s_tdata[7:0];
    assign str_cmd = s_tdata[15:8];
    assign s_take  = s_tvalid && s_tready;

    always_comb begin
        if (speed_reg < thr_cmd) begin
            ramp_speed = speed_reg + 8'sd1;
        end else if (speed_reg > thr_cmd) begin
            ramp_speed = speed_reg - 8'sd1;
        end else begin
            ramp_speed = speed_reg;
        end
        if (turn_reg < str_cmd) begin
            ramp_turn = turn_reg + 8'sd1;
        end else if (turn_reg > str_cmd) begin
            ramp_turn = turn_reg - 8'sd1;
        end else begin
            ramp_turn = turn_reg;
        end
    end

    // In idle the left side is loaded from the freshly ramped values.
    assign load_side = (state_reg == S_IDLE) ? 1'b0 : 1'b1;
    assign op_speed  = (state_reg == S_IDLE) ? ramp_speed : speed_reg;
    assign op_turn   = (state_reg == S_IDLE) ? ramp_turn : turn_reg;
    assign mix_diff  = MAG_W'(op_speed) - MAG_W'(op_turn);
    assign mix_sum   = MAG_W'(op_speed) + MAG_W'(op_turn);
    assign mix_val   = load_side ? mix_sum : mix_diff;
    assign mix_mag   = mix_val[MAG_W-1] ? MAG_W'(-mix_val) : MAG_W'(mix_val);

    assign div_eff   = (handicap_reg == '0) ? DIV_W'(1) : handicap_reg;
    assign trial     = {rem_reg, quo_reg[MAG_W-1]};
    assign trial_ge  = trial >= {1'b0, div_eff};
    assign quo_shift = {quo_reg[MAG_W-2:0], trial_ge};

    assign clamped   = (quo_shift > LIMIT) ? LIMIT : quo_shift;
    assign position  = neg_reg ? (rdm_pkg::CENTER_POS - clamped[POS_W-1:0])
                               : (rdm_pkg::CENTER_POS + clamped[POS_W-1:0]);

    always_comb begin
        state_next    = state_reg;
        side_next     = side_reg;
        step_next     = step_reg;
        rem_next      = rem_reg;
        quo_next      = quo_reg;
        neg_next      = neg_reg;
        left_next     = left_reg;
        speed_next    = speed_reg;
        turn_next     = turn_reg;
        m_tvalid_next = m_tvalid_reg;
        m_tdata_next  = m_tdata_reg;

        if (m_tvalid_reg && m_tready) begin
            m_tvalid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE: begin
                if (s_take) begin
                    speed_next = ramp_speed;
                    turn_next  = ramp_turn;
                    side_next  = 1'b0;
                    step_next  = '0;
                    rem_next   = '0;
                    quo_next   = mix_mag;
                    neg_next   = mix_val[MAG_W-1] ^ reverse_reg;
                    state_next = S_DIV;
                end
            end
            S_DIV: begin
                rem_next = trial_ge ? DIV_W'(trial - {1'b0, div_eff}) : trial[DIV_W-1:0];
                quo_next = quo_shift;
                step_next = step_reg + STEP_W'(1);
                if (step_reg == LAST_STEP) begin
                    if (!side_reg) begin
                        left_next = position;
                        side_next = 1'b1;
                        step_next = '0;
                        rem_next  = '0;
                        quo_next  = mix_mag;
                        neg_next  = mix_val[MAG_W-1] ^ reverse_reg ^ 1'b1;
                    end else begin
                        state_next = S_DONE;
                    end
                end
            end
            S_DONE: begin
                if (!m_tvalid_reg || m_tready) begin
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = {right_reg, left_reg};
                    state_next    = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign right_next = (state_reg == S_DIV && side_reg && step_reg == LAST_STEP)
                      ? position : right_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_IDLE;
            speed_reg    <= '0;
            turn_reg     <= '0;
            m_tvalid_reg <= 1'b0;
            handicap_reg <= rdm_pkg::HANDICAP_RESET;
            reverse_reg  <= 1'b0;
        end else begin
            state_reg    <= state_next;
            speed_reg    <= speed_next;
            turn_reg     <= turn_next;
            m_tvalid_reg <= m_tvalid_next;
            if (cfg_write) begin
                unique case (paddr[2])
                    rdm_pkg::REG_HANDICAP: handicap_reg <= pwdata[DIV_W-1:0];
                    rdm_pkg::REG_REVERSE:  reverse_reg  <= pwdata[0];
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge aclk) begin
        side_reg    <= side_next;
        step_reg    <= step_next;
        rem_reg     <= rem_next;
        quo_reg     <= quo_next;
        neg_reg     <= neg_next;
        left_reg    <= left_next;
        right_reg   <= right_next;
        m_tdata_reg <= m_tdata_next;
    end

    assign s_tready  = (state_reg == S_IDLE);
    assign m_tvalid  = m_tvalid_reg;
    assign m_tdata   = m_tdata_reg;

    assign cfg_write = psel && penable && pwrite && pready;
    assign pready    = 1'b1;

    always_comb begin
        unique case (paddr[2])
            rdm_pkg::REG_HANDICAP: prdata = 32'(handicap_reg);
            rdm_pkg::REG_REVERSE:  prdata = 32'(reverse_reg);
            default:               prdata = '0;
        endcase
    end

endmodule

`default_nettype wire

// ===== rtl/core/rdm_checker.sv =====
`default_nettype none

module rdm_checker (
    input wire logic        aclk,
    input wire logic        aresetn,
    input wire logic        s_tvalid,
    input wire logic        s_tready,
    input wire logic        m_tvalid,
    input wire logic        m_tready,
    input wire logic [15:0] m_tdata,
    input wire logic        pready
);

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed while stalled");

    a_pos_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[7:0] <= rdm_pkg::MAX_POS) &&
                     (m_tdata[15:8] <= rdm_pkg::MAX_POS))
        else $error("servo position out of range");

    a_busy_after_take: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("request taken while still working");

    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result present after reset");

    a_pready: assert property (@(posedge aclk) disable iff (!aresetn)
        pready)
        else $error("pready dropped");

endmodule

bind ramped_differential_drive_mixer rdm_checker u_rdm_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .pready   (pready)
);

`default_nettype wire
